[rtl/core/b64d_pkg.sv]
`default_nettype none

package b64d_pkg;

    localparam int COUNT_BITS_DEF = 16;

    localparam logic [15:0] LIMIT_RESET = 16'hFFFF;
    localparam logic [7:0]  PAD_CHAR    = 8'h3D;
    localparam logic [5:0]  SYM_PLUS    = 6'(2 * 26 + 10);
    localparam logic [5:0]  SYM_SLASH   = 6'(2 * 26 + 11);

    localparam logic KIND_DATA    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef enum logic [1:0] {
        CAUSE_DONE      = 2'd0,
        CAUSE_MALFORMED = 2'd1,
        CAUSE_LIMIT     = 2'd2
    } cause_t;

    // Partial quartet and per-string decode status
    typedef struct packed {
        logic [23:0] bits;
        logic [1:0]  fill;
        logic [2:0]  pads;
        logic        pad_sym;
        logic        stopped;
        cause_t      reason;
    } grp_t;

    // Results caused by one request: up to three bytes, then maybe a summary
    typedef struct packed {
        logic [1:0]      n_bytes;
        logic [2:0][7:0] data;
        logic            summary;
        cause_t          cause;
    } bundle_t;

    // {hit, 6-bit value}
    function automatic logic [6:0] sym_decode(input logic [7:0] c);
        logic [6:0] r;
        r = '0;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r = {1'b1, 6'(c - 8'h41)};
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            r = {1'b1, 6'(c - 8'h61 + 8'd26)};
        end else if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 6'(c - 8'h30 + 8'd52)};
        end else if (c == 8'h2B) begin
            r = {1'b1, SYM_PLUS};
        end else if (c == 8'h2F) begin
            r = {1'b1, SYM_SLASH};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/core/b64d_ifs.sv]
`default_nettype none

interface b64d_in_if;
    logic       valid;
    logic       ready;
    logic       char_present;
    logic [7:0] in_char;
    logic       end_of_text;

    modport source (output valid, char_present, in_char, end_of_text, input ready);
    modport sink   (input valid, char_present, in_char, end_of_text, output ready);
endinterface

interface b64d_out_if;
    logic        valid;
    logic        ready;
    logic        item_kind;
    logic [7:0]  out_byte;
    logic [15:0] bytes_total;
    logic [1:0]  stop_cause;
    logic        last_result;

    modport source (output valid, item_kind, out_byte, bytes_total, stop_cause,
                    last_result, input ready);
    modport sink   (input valid, item_kind, out_byte, bytes_total, stop_cause,
                    last_result, output ready);
endinterface

interface b64d_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] output_limit;

    modport source (output valid, output_limit, input ready);
    modport sink   (input valid, output_limit, output ready);
endinterface

`default_nettype wire

[rtl/core/b64d_step.sv]
`default_nettype none

module b64d_step
    import b64d_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  grp_t                  grp,
    input  logic [COUNT_BITS-1:0] count,
    input  logic [15:0]           limit,
    input  logic                  char_present,
    input  logic [7:0]            in_char,
    input  logic                  end_of_text,
    output grp_t                  grp_next,
    output logic [COUNT_BITS-1:0] count_next,
    output bundle_t               bundle
);

    localparam int LW = ((COUNT_BITS > 16) ? COUNT_BITS : 16) + 1;
    localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

    logic [6:0]  sym;
    logic        is_pad;
    logic        fin;
    logic [23:0] f_bits;
    logic [2:0]  f_pads;
    logic        f_pts;
    logic [1:0]  n;
    logic [LW-1:0] sum;

    assign sym    = sym_decode(in_char);
    assign is_pad = (in_char == PAD_CHAR);
    assign sum    = LW'(count) + LW'(n);
    assign n      = (f_pads >= 3'd3) ? 2'd0 : 2'(3'd3 - f_pads);

    always_comb
    begin
        grp_next   = grp;
        count_next = count;
        bundle     = '0;
        fin        = 1'b0;
        f_bits     = grp.bits;
        f_pads     = grp.pads;
        f_pts      = grp.pad_sym;

        // take one character
        if (char_present && !grp.stopped && (is_pad || sym[6])) begin
            grp_next.bits = {grp.bits[17:0], is_pad ? 6'd0 : sym[5:0]};
            grp_next.pads = is_pad ? grp.pads + 3'd1 : grp.pads;
            grp_next.pad_sym = grp.pad_sym | (!is_pad && grp.pads != 3'd0);
            if (grp.fill == 2'd3) begin
                fin    = 1'b1;
                f_bits = grp_next.bits;
                f_pads = grp_next.pads;
                f_pts  = grp_next.pad_sym;
            end else begin
                grp_next.fill = grp.fill + 2'd1;
            end
        end

        // end of text: pad out a partial quartet
        if (end_of_text && !grp.stopped && !fin && grp_next.fill != 2'd0) begin
            fin    = 1'b1;
            f_pts  = grp_next.pad_sym;
            f_pads = grp_next.pads + 3'(3'd4 - {1'b0, grp_next.fill});
            case (grp_next.fill)
                2'd1:    f_bits = {grp_next.bits[5:0], 18'd0};
                2'd2:    f_bits = {grp_next.bits[11:0], 12'd0};
                default: f_bits = {grp_next.bits[17:0], 6'd0};
            endcase
        end

        if (fin) begin
            grp_next.bits    = '0;
            grp_next.fill    = '0;
            grp_next.pads    = '0;
            grp_next.pad_sym = 1'b0;
            if (f_pts) begin
                grp_next.stopped = 1'b1;
                grp_next.reason  = CAUSE_MALFORMED;
            end else if (sum > LW'(limit) || sum > LW'(CMAX)) begin
                grp_next.stopped = 1'b1;
                grp_next.reason  = CAUSE_LIMIT;
            end else begin
                bundle.n_bytes = n;
                bundle.data[0] = f_bits[23:16];
                bundle.data[1] = f_bits[15:8];
                bundle.data[2] = f_bits[7:0];
                count_next     = count + COUNT_BITS'(n);
                if (n != 2'd3) begin
                    grp_next.stopped = 1'b1;
                    grp_next.reason  = CAUSE_DONE;
                end
            end
        end

        if (end_of_text) begin
            if (!grp_next.stopped) begin
                grp_next.reason = CAUSE_DONE;
            end
            bundle.summary = 1'b1;
            bundle.cause   = grp_next.reason;
            grp_next       = '0;
            count_next     = '0;
        end
    end

endmodule

`default_nettype wire

[rtl/core/base64_stream_decoder_core.sv]
`default_nettype none
// Latency: a request shows its first result on the cycle after acceptance.
// Throughput: one request per cycle when it yields at most one result and the output is
// ready; a request yielding several results (up to three bytes and a summary) holds the output
// until the single result register has drained them, one item per cycle while the output is ready.
// Reset (rst_n, async, active low) clears decode state and sets output_limit to 65535.

module base64_stream_decoder_core
    import b64d_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    b64d_in_if.sink    chars_in,
    b64d_out_if.source items_out,
    b64d_cfg_if.sink   cfg
);

    // Decode state, held across requests
    grp_t                  grp_reg;
    grp_t                  grp_next;
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    logic [15:0]           limit_reg;

    // Result register: results of one request, drained one item a cycle while the output is ready
    bundle_t               bundle_reg;
    bundle_t               bundle_next;
    logic [COUNT_BITS-1:0] base_reg;
    logic                  bv_reg;
    logic [1:0]            pos_reg;

    logic                  in_fire;
    logic                  out_fire;
    logic                  has_results;
    logic [2:0]            items_total;
    logic                  pos_last;
    logic                  is_byte;
    logic [1:0]            sel;
    logic [COUNT_BITS-1:0] total;
    logic [7:0]            cur_byte;

    b64d_step #(
        .COUNT_BITS (COUNT_BITS)
    ) u_step (
        .grp          (grp_reg),
        .count        (count_reg),
        .limit        (limit_reg),
        .char_present (chars_in.char_present),
        .in_char      (chars_in.in_char),
        .end_of_text  (chars_in.end_of_text),
        .grp_next     (grp_next),
        .count_next   (count_next),
        .bundle       (bundle_next)
    );

    assign cfg.ready = 1'b1;

    // Drain position within the held results
    assign items_total = {1'b0, bundle_reg.n_bytes} + {2'b00, bundle_reg.summary};
    assign pos_last    = ({1'b0, pos_reg} + 3'd1) == items_total;
    assign is_byte     = pos_reg < bundle_reg.n_bytes;

    // Accept a new request when nothing is held or while the last held item leaves
    assign chars_in.ready = !bv_reg || (items_out.ready && pos_last);
    assign in_fire        = chars_in.valid && chars_in.ready;
    assign out_fire       = items_out.valid && items_out.ready;
    assign has_results    = (bundle_next.n_bytes != 2'd0) || bundle_next.summary;

    always_comb
    begin
        case (pos_reg)
            2'd0:    cur_byte = bundle_reg.data[0];
            2'd1:    cur_byte = bundle_reg.data[1];
            default: cur_byte = bundle_reg.data[2];
        endcase
    end

    // Bytes so far: base plus position plus one for a data byte, base plus all bytes for a summary
    assign sel   = is_byte ? pos_reg + 2'd1 : bundle_reg.n_bytes;
    assign total = base_reg + COUNT_BITS'(sel);

    assign items_out.valid       = bv_reg;
    assign items_out.item_kind   = is_byte ? KIND_DATA : KIND_SUMMARY;
    assign items_out.out_byte    = is_byte ? cur_byte : 8'd0;
    assign items_out.bytes_total = 16'(total);
    assign items_out.stop_cause  = is_byte ? CAUSE_DONE : bundle_reg.cause;
    assign items_out.last_result = !is_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            grp_reg   <= '0;
            count_reg <= '0;
            limit_reg <= LIMIT_RESET;
            bv_reg    <= 1'b0;
            pos_reg   <= '0;
        end else begin
            if (cfg.valid) begin
                limit_reg <= cfg.output_limit;
            end
            if (in_fire) begin
                grp_reg   <= grp_next;
                count_reg <= count_next;
            end
            if (in_fire && has_results) begin
                bv_reg  <= 1'b1;
                pos_reg <= '0;
            end else if (out_fire) begin
                if (pos_last) begin
                    bv_reg <= 1'b0;
                end else begin
                    pos_reg <= pos_reg + 2'd1;
                end
            end
        end
    end

    // Payload only
    always_ff @(posedge clk)
    begin
        if (in_fire && has_results) begin
            bundle_reg <= bundle_next;
            base_reg   <= count_reg;
        end
    end

    // No new request while held results remain after this cycle
    a_hold_full: assert property (@(posedge clk) disable iff (!rst_n)
        (bv_reg && !(items_out.ready && pos_last)) |-> !chars_in.ready)
        else $error("request taken while results still held");

    // A summary is always the last held item
    a_summary_last: assert property (@(posedge clk) disable iff (!rst_n)
        (items_out.valid && items_out.item_kind == KIND_SUMMARY) |-> pos_last)
        else $error("summary not last of its group");

    // Within one group, byte totals step by one and a summary repeats the last total
    a_total_step: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && items_out.item_kind == KIND_DATA && !pos_last) |=>
        (items_out.valid &&
         ((items_out.item_kind == KIND_SUMMARY &&
           items_out.bytes_total == $past(items_out.bytes_total)) ||
          (items_out.item_kind == KIND_DATA &&
           items_out.bytes_total == $past(items_out.bytes_total) + 16'd1))))
        else $error("byte total out of step");

    // A quartet never holds more than three pads
    a_pads_bound: assert property (@(posedge clk) disable iff (!rst_n)
        grp_reg.pads <= 3'd3)
        else $error("pad count overrun");

endmodule

`default_nettype wire
